// File: rtl/core/crup_pkg.sv
package crup_pkg;

  localparam int COORD_BITS = 12;
  localparam int COEF_BITS  = 21;
  localparam int CFG_W      = 63;
  localparam int SIZE_W     = 13;
  localparam int NDC_W      = 22;
  localparam int ACC_W      = 44;
  localparam int V_W        = 66;
  localparam int NM_W       = 30;
  localparam int LEN_W      = NM_W + 1;
  localparam int DIR_W      = 16;

  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(1080);

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_MATRIX_ROW_X  = 3'd2,
    REG_MATRIX_ROW_Y  = 3'd3,
    REG_MATRIX_ROW_Z  = 3'd4,
    REG_MATRIX_ROW_W  = 3'd5,
    REG_CAMERA_ORIGIN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic                    degenerate;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [CFG_W-1:0]  row_x;
    logic [CFG_W-1:0]  row_y;
    logic [CFG_W-1:0]  row_z;
    logic [CFG_W-1:0]  row_w;
    logic [CFG_W-1:0]  origin;
  } cfg_t;

  // normalized magnitudes and signs that travel beside the length computation
  typedef struct packed {
    logic [2:0][NM_W-1:0] mag;
    logic [2:0]           neg;
    logic                 degen;
  } side_t;

  function automatic logic signed [COEF_BITS-1:0] coef_get(input logic [CFG_W-1:0] r,
                                                           input int unsigned k);
    coef_get = r[k*COEF_BITS +: COEF_BITS];
  endfunction

endpackage

// File: rtl/core/camera_ray_unproject.sv
// Primary ray generator for a pinhole camera.
// Input channel in_valid/in_ready/in_data carries one pixel (column, row) per item.
// Result channel out_valid/out_ready/out_data carries the unit direction in Q1.15
// and a degenerate flag (w of zero or zero vector; direction is then zero).
// Configuration: cfg_we writes cfg_wdata to register cfg_addr:
// 0 frame width, 1 frame height, 2..5 matrix rows x/y/z/w, 6 camera origin.
// Write registers only while no item is in flight.
// An accepted item passes in order through the pixel-to-ndc divider, the matrix
// transform, magnitude normalization, the square root (two result bits per stage)
// and the final per-component divider. Throughput is one item per cycle unless
// the output stalls; every stage is a register with a valid bit.
// When out_ready is low with a result waiting, the whole pipeline holds and
// in_ready drops; nothing is lost or repeated. Otherwise the pipeline advances.
// Reset (synchronous, rst_n low) clears all valid bits and sets the frame size to
// 1920x1080 and the matrix and origin to zero.
module camera_ray_unproject (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  crup_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output crup_pkg::out_item_t          out_data,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_addr,
  input  logic [crup_pkg::CFG_W-1:0]   cfg_wdata
);
  import crup_pkg::*;

  cfg_t cfg_r;
  logic en;

  logic                    ndc_valid;
  logic signed [NDC_W-1:0] ndc_x, ndc_y;
  logic                    xf_valid, xf_wzero;
  logic [2:0][V_W-1:0]     xf_v;
  logic                    nm_valid;
  side_t                   nm_side;
  logic [LEN_W-1:0]        nm_len;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= FRAME_WIDTH_RST;
      cfg_r.frame_height <= FRAME_HEIGHT_RST;
      cfg_r.row_x        <= '0;
      cfg_r.row_y        <= '0;
      cfg_r.row_z        <= '0;
      cfg_r.row_w        <= '0;
      cfg_r.origin       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:   cfg_r.frame_width  <= cfg_wdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:  cfg_r.frame_height <= cfg_wdata[SIZE_W-1:0];
        REG_MATRIX_ROW_X:  cfg_r.row_x        <= cfg_wdata;
        REG_MATRIX_ROW_Y:  cfg_r.row_y        <= cfg_wdata;
        REG_MATRIX_ROW_Z:  cfg_r.row_z        <= cfg_wdata;
        REG_MATRIX_ROW_W:  cfg_r.row_w        <= cfg_wdata;
        REG_CAMERA_ORIGIN: cfg_r.origin       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  crup_ndc u_ndc (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .in_item      (in_data),
    .frame_width  (cfg_r.frame_width),
    .frame_height (cfg_r.frame_height),
    .out_valid    (ndc_valid),
    .ndc_x        (ndc_x),
    .ndc_y        (ndc_y)
  );

  crup_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ndc_valid),
    .ndc_x     (ndc_x),
    .ndc_y     (ndc_y),
    .cfg       (cfg_r),
    .out_valid (xf_valid),
    .out_wzero (xf_wzero),
    .v_out     (xf_v)
  );

  crup_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (xf_valid),
    .in_wzero  (xf_wzero),
    .v_in      (xf_v),
    .out_valid (nm_valid),
    .out_side  (nm_side),
    .out_len   (nm_len)
  );

  crup_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (nm_valid),
    .in_side   (nm_side),
    .in_len    (nm_len),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

// File: rtl/core/crup_ndc.sv
module crup_ndc (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  crup_pkg::in_item_t                  in_item,
  input  logic [crup_pkg::SIZE_W-1:0]         frame_width,
  input  logic [crup_pkg::SIZE_W-1:0]         frame_height,
  output logic                                out_valid,
  output logic signed [crup_pkg::NDC_W-1:0]   ndc_x,
  output logic signed [crup_pkg::NDC_W-1:0]   ndc_y
);
  import crup_pkg::*;

  localparam int NUM_W = COORD_BITS + 19;
  localparam int QB    = 21;
  localparam int NSTG  = 3;
  localparam int BPS   = QB / NSTG;
  localparam int D_W   = SIZE_W + 1;
  localparam int R_W   = D_W + 1;
  localparam int NDC_ONE = 65536;
  localparam int NDC_MAX = 1048575;

  logic [NUM_W-1:0] num_r   [2][NSTG];
  logic [NUM_W-1:0] num_nxt [2][NSTG];
  logic [D_W-1:0]   d_r     [2][NSTG];
  logic [D_W-1:0]   d_nxt   [2][NSTG];
  logic [R_W-1:0]   rem_r   [2][NSTG];
  logic [R_W-1:0]   rem_nxt [2][NSTG];
  logic [QB-1:0]    q_r     [2][NSTG];
  logic [QB-1:0]    q_nxt   [2][NSTG];
  logic             sat_r   [2][NSTG];
  logic             sat_nxt [2][NSTG];
  logic [NSTG:0]    vld_r;
  logic signed [NDC_W-1:0] ndc_r   [2];
  logic signed [NDC_W-1:0] ndc_nxt [2];

  always_comb begin
    logic [SIZE_W-1:0]     s;
    logic [COORD_BITS-1:0] p;
    logic [NUM_W-1:0]      num;
    logic [D_W-1:0]        d;
    logic [R_W-1:0]        rem;
    logic [QB-1:0]         q;
    logic                  sat;
    int                    b;
    for (int l = 0; l < 2; l++) begin
      for (int st = 0; st < NSTG; st++) begin
        if (st == 0) begin
          p = (l == 0) ? in_item.pixel_x : in_item.pixel_y;
          s = (l == 0) ? frame_width : frame_height;
          if (s == '0) s = SIZE_W'(1);
          d   = {s, 1'b0};
          num = (NUM_W'({p, 1'b1}) << 17) + NUM_W'(s);
          sat = (num >> QB) >= NUM_W'(d);
          rem = R_W'(num >> QB);
          q   = '0;
        end else begin
          num = num_r[l][st-1];
          d   = d_r[l][st-1];
          rem = rem_r[l][st-1];
          q   = q_r[l][st-1];
          sat = sat_r[l][st-1];
        end
        for (int k = 0; k < BPS; k++) begin
          b   = QB - 1 - (st * BPS + k);
          rem = {rem[R_W-2:0], num[b]};
          if (rem >= R_W'(d)) begin
            rem  = rem - R_W'(d);
            q[b] = 1'b1;
          end
        end
        num_nxt[l][st] = num;
        d_nxt[l][st]   = d;
        rem_nxt[l][st] = rem;
        q_nxt[l][st]   = q;
        sat_nxt[l][st] = sat;
      end
      if (sat_r[l][NSTG-1] || (q_r[l][NSTG-1] > QB'(NDC_MAX + NDC_ONE))) begin
        ndc_nxt[l] = NDC_W'(NDC_MAX);
      end else begin
        ndc_nxt[l] = $signed({1'b0, q_r[l][NSTG-1]}) - NDC_W'(NDC_ONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      d_r   <= d_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      sat_r <= sat_nxt;
      ndc_r <= ndc_nxt;
    end
  end

  assign out_valid = vld_r[NSTG];
  assign ndc_x     = ndc_r[0];
  assign ndc_y     = ndc_r[1];

endmodule

// File: rtl/core/crup_xform.sv
module crup_xform (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic signed [crup_pkg::NDC_W-1:0]     ndc_x,
  input  logic signed [crup_pkg::NDC_W-1:0]     ndc_y,
  input  crup_pkg::cfg_t                        cfg,
  output logic                                  out_valid,
  output logic                                  out_wzero,
  output logic [2:0][crup_pkg::V_W-1:0]         v_out
);
  import crup_pkg::*;

  localparam int PROD_W = COEF_BITS + NDC_W;
  localparam int WL     = ACC_W / 2;
  localparam int WH     = ACC_W - WL;
  localparam int PL_W   = COEF_BITS + WL + 1;
  localparam int PH_W   = COEF_BITS + WH;

  logic [CFG_W-1:0] rows [4];

  logic signed [PROD_W-1:0]    p0_r [4];
  logic signed [PROD_W-1:0]    p1_r [4];
  logic signed [COEF_BITS-1:0] c2_r [4];
  logic signed [ACC_W-1:0]     acc_r [4];
  logic signed [PL_W-1:0]      pl_r [3];
  logic signed [PH_W-1:0]      ph_r [3];
  logic signed [V_W-1:0]       ash_r [3];
  logic                        wneg_r, wzero3_r, wzero4_r;
  logic signed [V_W-1:0]       v_r [3];
  logic [3:0]                  vld_r;

  logic signed [PROD_W-1:0]    p0_nxt [4];
  logic signed [PROD_W-1:0]    p1_nxt [4];
  logic signed [COEF_BITS-1:0] c2_nxt [4];
  logic signed [ACC_W-1:0]     acc_nxt [4];
  logic signed [PL_W-1:0]      pl_nxt [3];
  logic signed [PH_W-1:0]      ph_nxt [3];
  logic signed [V_W-1:0]       ash_nxt [3];
  logic signed [V_W-1:0]       v_nxt [3];

  assign rows[0] = cfg.row_x;
  assign rows[1] = cfg.row_y;
  assign rows[2] = cfg.row_z;
  assign rows[3] = cfg.row_w;

  always_comb begin
    logic signed [COEF_BITS-1:0] c0, c1, o;
    logic signed [WL:0]          wl_s;
    logic signed [WH-1:0]        wh_s;
    logic signed [V_W-1:0]       ow, v;
    for (int i = 0; i < 4; i++) begin
      c0 = coef_get(rows[i], 0);
      c1 = coef_get(rows[i], 1);
      p0_nxt[i] = c0 * ndc_x;
      p1_nxt[i] = c1 * ndc_y;
      c2_nxt[i] = coef_get(rows[i], 2);
      acc_nxt[i] = ACC_W'(p0_r[i]) + ACC_W'(p1_r[i]) + (ACC_W'(c2_r[i]) <<< 16);
    end
    wl_s = $signed({1'b0, acc_r[3][WL-1:0]});
    wh_s = acc_r[3][ACC_W-1:WL];
    for (int i = 0; i < 3; i++) begin
      o          = coef_get(cfg.origin, i);
      pl_nxt[i]  = o * wl_s;
      ph_nxt[i]  = o * wh_s;
      ash_nxt[i] = V_W'(acc_r[i]) <<< 11;
      ow         = (V_W'(ph_r[i]) <<< WL) + V_W'(pl_r[i]);
      v          = ash_r[i] - ow;
      v_nxt[i]   = wneg_r ? -v : v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r     <= p0_nxt;
      p1_r     <= p1_nxt;
      c2_r     <= c2_nxt;
      acc_r    <= acc_nxt;
      pl_r     <= pl_nxt;
      ph_r     <= ph_nxt;
      ash_r    <= ash_nxt;
      wneg_r   <= acc_r[3][ACC_W-1];
      wzero3_r <= (acc_r[3] == '0);
      wzero4_r <= wzero3_r;
      v_r      <= v_nxt;
    end
  end

  assign out_valid = vld_r[3];
  assign out_wzero = wzero4_r;
  assign v_out[0]  = v_r[0];
  assign v_out[1]  = v_r[1];
  assign v_out[2]  = v_r[2];

endmodule

// File: rtl/core/crup_norm.sv
module crup_norm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic                            in_wzero,
  input  logic [2:0][crup_pkg::V_W-1:0]   v_in,
  output logic                            out_valid,
  output crup_pkg::side_t                 out_side,
  output logic [crup_pkg::LEN_W-1:0]      out_len
);
  import crup_pkg::*;

  localparam int MAG_W    = V_W - 1;
  localparam int SH_W     = $clog2(MAG_W);
  localparam int SQ1_W    = 2 * NM_W;
  localparam int SUM_W    = SQ1_W + 2;
  localparam int RT_W     = SUM_W + 1;
  localparam int SQ_STEPS = SUM_W / 2;
  localparam int SPS      = 2;
  localparam int SSTG     = (SQ_STEPS + SPS - 1) / SPS;
  localparam int NPRE     = 5;

  logic [MAG_W-1:0] m1_r [3];
  logic [2:0]       neg1_r;
  logic             wz1_r;
  logic [MAG_W-1:0] m2_r [3];
  logic [2:0]       neg2_r;
  logic             dg2_r;
  logic [SH_W-1:0]  msb2_r;
  side_t            side3_r, side4_r, side5_r;
  logic [SQ1_W-1:0] sq4_r [3];
  logic [SUM_W-1:0] sum5_r;
  logic [RT_W-1:0]  x_r   [SSTG];
  logic [RT_W-1:0]  r_r   [SSTG];
  side_t            sside_r [SSTG];
  logic [NPRE+SSTG-1:0] vld_r;

  logic [MAG_W-1:0] m1_nxt [3];
  logic [SH_W-1:0]  msb_nxt;
  logic             zero_nxt;
  side_t            side3_nxt;
  logic [SQ1_W-1:0] sq4_nxt [3];
  logic [RT_W-1:0]  x_nxt [SSTG];
  logic [RT_W-1:0]  r_nxt [SSTG];
  side_t            sside_nxt [SSTG];

  always_comb begin
    logic [MAG_W-1:0] orv;
    for (int i = 0; i < 3; i++) begin
      m1_nxt[i] = v_in[i][V_W-1] ? MAG_W'(-$signed(v_in[i])) : MAG_W'(v_in[i]);
    end
    orv      = m1_r[0] | m1_r[1] | m1_r[2];
    zero_nxt = (orv == '0);
    msb_nxt  = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (orv[b]) msb_nxt = SH_W'(b);
    end
    for (int i = 0; i < 3; i++) begin
      if (msb2_r >= SH_W'(NM_W - 1)) begin
        side3_nxt.mag[i] = NM_W'(m2_r[i] >> (msb2_r - SH_W'(NM_W - 1)));
      end else begin
        side3_nxt.mag[i] = NM_W'(m2_r[i] << (SH_W'(NM_W - 1) - msb2_r));
      end
      sq4_nxt[i] = SQ1_W'(side3_r.mag[i]) * SQ1_W'(side3_r.mag[i]);
    end
    side3_nxt.neg   = neg2_r;
    side3_nxt.degen = dg2_r;
  end

  always_comb begin
    logic [RT_W-1:0] x, r, bt;
    int              j;
    for (int s = 0; s < SSTG; s++) begin
      if (s == 0) begin
        x            = RT_W'(sum5_r);
        r            = '0;
        sside_nxt[s] = side5_r;
      end else begin
        x            = x_r[s-1];
        r            = r_r[s-1];
        sside_nxt[s] = sside_r[s-1];
      end
      for (int k = 0; k < SPS; k++) begin
        j = s * SPS + k;
        if (j < SQ_STEPS) begin
          bt = RT_W'(1) << (2 * (SQ_STEPS - 1 - j));
          if (x >= r + bt) begin
            x = x - (r + bt);
            r = (r >> 1) + bt;
          end else begin
            r = r >> 1;
          end
        end
      end
      x_nxt[s] = x;
      r_nxt[s] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NPRE+SSTG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= m1_nxt;
      neg1_r  <= {v_in[2][V_W-1], v_in[1][V_W-1], v_in[0][V_W-1]};
      wz1_r   <= in_wzero;
      m2_r    <= m1_r;
      neg2_r  <= neg1_r;
      dg2_r   <= wz1_r | zero_nxt;
      msb2_r  <= msb_nxt;
      side3_r <= side3_nxt;
      sq4_r   <= sq4_nxt;
      side4_r <= side3_r;
      sum5_r  <= SUM_W'(sq4_r[0]) + SUM_W'(sq4_r[1]) + SUM_W'(sq4_r[2]);
      side5_r <= side4_r;
      x_r     <= x_nxt;
      r_r     <= r_nxt;
      sside_r <= sside_nxt;
    end
  end

  assign out_valid = vld_r[NPRE+SSTG-1];
  assign out_side  = sside_r[SSTG-1];
  assign out_len   = r_r[SSTG-1][LEN_W-1:0];

endmodule

// File: rtl/core/crup_scale.sv
module crup_scale (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  crup_pkg::side_t             in_side,
  input  logic [crup_pkg::LEN_W-1:0]  in_len,
  output logic                        out_valid,
  output crup_pkg::out_item_t         out_item
);
  import crup_pkg::*;

  localparam int QW     = DIR_W;
  localparam int DSTG   = 4;
  localparam int DPS    = QW / DSTG;
  localparam int D_W    = LEN_W + 1;
  localparam int R_W    = D_W + 1;
  localparam int NUMW   = NM_W + QW + 1;
  localparam logic [DIR_W-1:0] POS_MAX = DIR_W'(32767);
  localparam logic [DIR_W-1:0] NEG_MAX = DIR_W'(32768);

  logic [D_W-1:0] d_r     [DSTG];
  logic [D_W-1:0] d_nxt   [DSTG];
  logic [QW-1:0]  lo_r    [DSTG][3];
  logic [QW-1:0]  lo_nxt  [DSTG][3];
  logic [R_W-1:0] rem_r   [DSTG][3];
  logic [R_W-1:0] rem_nxt [DSTG][3];
  logic [QW-1:0]  q_r     [DSTG][3];
  logic [QW-1:0]  q_nxt   [DSTG][3];
  side_t          side_r  [DSTG];
  side_t          side_nxt[DSTG];
  logic [DSTG:0]  vld_r;
  out_item_t      item_r, item_nxt;

  always_comb begin
    logic [NUMW-1:0]  num;
    logic [D_W-1:0]   d;
    logic [QW-1:0]    lo, q;
    logic [R_W-1:0]   rem;
    logic [DIR_W-1:0] dd;
    logic [DIR_W-1:0] o [3];
    int               b;
    for (int st = 0; st < DSTG; st++) begin
      side_nxt[st] = (st == 0) ? in_side : side_r[(st == 0) ? 0 : st - 1];
      d = (st == 0) ? {in_len, 1'b0} : d_r[(st == 0) ? 0 : st - 1];
      d_nxt[st] = d;
      for (int l = 0; l < 3; l++) begin
        if (st == 0) begin
          num = (NUMW'(in_side.mag[l]) << QW) + NUMW'(in_len);
          lo  = num[QW-1:0];
          rem = R_W'(num >> QW);
          q   = '0;
        end else begin
          lo  = lo_r[st-1][l];
          rem = rem_r[st-1][l];
          q   = q_r[st-1][l];
        end
        for (int k = 0; k < DPS; k++) begin
          b   = QW - 1 - (st * DPS + k);
          rem = {rem[R_W-2:0], lo[b]};
          if (rem >= R_W'(d)) begin
            rem  = rem - R_W'(d);
            q[b] = 1'b1;
          end
        end
        lo_nxt[st][l]  = lo;
        rem_nxt[st][l] = rem;
        q_nxt[st][l]   = q;
      end
    end
    for (int l = 0; l < 3; l++) begin
      dd = q_r[DSTG-1][l];
      if (side_r[DSTG-1].neg[l]) begin
        if (dd > NEG_MAX) dd = NEG_MAX;
        o[l] = DIR_W'(0) - dd;
      end else begin
        if (dd > POS_MAX) dd = POS_MAX;
        o[l] = dd;
      end
      if (side_r[DSTG-1].degen) o[l] = '0;
    end
    item_nxt.dir_x      = o[0];
    item_nxt.dir_y      = o[1];
    item_nxt.dir_z      = o[2];
    item_nxt.degenerate = side_r[DSTG-1].degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DSTG-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= d_nxt;
      lo_r   <= lo_nxt;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      side_r <= side_nxt;
      item_r <= item_nxt;
    end
  end

  assign out_valid = vld_r[DSTG];
  assign out_item  = item_r;

endmodule

// File: rtl/core/crup_checker.sv
module crup_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input crup_pkg::out_item_t  out_data
);
  import crup_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled item changed or dropped");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is held");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.dir_x == '0 && out_data.dir_y == '0 && out_data.dir_z == '0)
    else $error("degenerate item with nonzero direction");

  a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.degenerate |->
      out_data.dir_x != '0 || out_data.dir_y != '0 || out_data.dir_z != '0)
    else $error("normal item with zero direction");

endmodule

bind camera_ray_unproject crup_checker u_crup_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
